// ===== design/xyz_to_srgb_encoder_assert.svh =====
// Assertion macros for the XYZ to sRGB encoder.
`ifndef XYZ_TO_SRGB_ENCODER_ASSERT_SVH
`define XYZ_TO_SRGB_ENCODER_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define XSE_ASSERT_HOLDS(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xyz_to_srgb_encoder: same-cycle check failed");

// Next-cycle implication, off while reset is high.
`define XSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xyz_to_srgb_encoder: next-cycle check failed");

`endif

// ===== design/xyz2srgb_pkg.sv =====
// Constants, matrix coefficients and gamma threshold functions for the XYZ to sRGB encoder.
package xyz2srgb_pkg;

  localparam int NUM_CH    = 3;
  localparam int IN_W      = 16;
  localparam int COEF_FRAC = 14;
  localparam int COEF_W    = 17;
  localparam int PROD_W    = IN_W + 1 + COEF_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int BIG_W     = 512;

  typedef logic [BIG_W-1:0] big_t;

  // XYZ (D65) to linear sRGB, Q14, row per output channel (R, G, B).
  localparam logic signed [COEF_W-1:0] XFORM [NUM_CH*NUM_CH] = '{
    17'sd53094, -17'sd25185, -17'sd8169,
    -17'sd15874, 17'sd30733, 17'sd680,
    17'sd913, -17'sd3342, 17'sd17318
  };

  // True when K*f(c/M) >= k - 1/2, evaluated exactly.
  function automatic bit gamma_reaches(longint unsigned c, longint unsigned k,
                                       int lin_bits, int out_bits);
    longint unsigned mx;
    longint unsigned kx;
    longint unsigned a;
    longint unsigned b;
    big_t lhs;
    big_t rhs;
    bit lin;
    mx  = (64'd1 << lin_bits) - 64'd1;
    kx  = (64'd1 << out_bits) - 64'd1;
    lin = (c * 64'd10000000) <= (64'd31308 * mx);
    if (lin) begin
      return (64'd1292 * c * 64'd2 * kx) >= (64'd100 * (64'd2 * k - 64'd1) * mx);
    end
    // (c/M)^(5/12) >= A/B  <=>  c^5 * B^12 >= A^12 * M^5
    a   = (64'd2 * k - 64'd1) * 64'd1000 + 64'd110 * kx;
    b   = 64'd2110 * kx;
    lhs = big_t'(1);
    rhs = big_t'(1);
    for (int i = 0; i < 5; i++) lhs = lhs * big_t'(c);
    for (int i = 0; i < 12; i++) lhs = lhs * big_t'(b);
    for (int i = 0; i < 12; i++) rhs = rhs * big_t'(a);
    for (int i = 0; i < 5; i++) rhs = rhs * big_t'(mx);
    return lhs >= rhs;
  endfunction

  // Smallest linear code whose encoded value rounds to at least k; M+1 if none.
  function automatic int gamma_threshold(int k, int lin_bits, int out_bits);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    if (k == 0) begin
      return 0;
    end
    lo = 64'd0;
    hi = 64'd1 << lin_bits;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (gamma_reaches(mid, longint'(k), lin_bits, out_bits)) begin
        hi = mid;
      end else begin
        lo = mid + 64'd1;
      end
    end
    return int'(lo);
  endfunction

endpackage

// ===== design/xyz_to_srgb_encoder.sv =====
// Top level of the CIE XYZ to 8-bit gamma-encoded sRGB pixel encoder.
`include "xyz_to_srgb_encoder_assert.svh"

// Converts one pixel per clock when not stalled, from CIE XYZ (unsigned, IN_FRAC_BITS
// fraction bits) to gamma-encoded sRGB codes of OUT_BITS bits. The pipeline has
// four register stages: input register, the nine matrix products (one 17x17
// multiplier each), the rounded and saturated linear codes (LINEAR_BITS,
// all-ones meaning 1.0, negatives clamp to 0), and the encoded result
// register. An item passes through these registers in that order, and a new
// item is accepted every cycle when not stalled. Each stage refills as soon as its
// successor moves, so input is still taken while a result waits at the
// output as long as an earlier stage is empty; s_axis_tready drops only when
// all four stages hold items and the output is stalled. The sRGB transfer
// curve is not stored as a per-code ROM: its 2^OUT_BITS step thresholds
// (the first linear code reaching each output code) are computed exactly at
// elaboration, and each channel finds its code with an OUT_BITS-step binary
// search over that table in the last stage. There is no reset pass and no
// configuration.
module xyz_to_srgb_encoder #(
  parameter int IN_FRAC_BITS = 14,
  parameter int LINEAR_BITS  = 12,
  parameter int OUT_BITS     = 8
) (
  input  logic clk,
  input  logic rst,
  // input pixel
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  logic [3*xyz2srgb_pkg::IN_W-1:0]          s_axis_tdata,  // x_tristim, y_tristim, z_tristim
  // encoded pixel
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  output logic [((3*OUT_BITS+7)/8)*8-1:0]          m_axis_tdata   // red_code, green_code, blue_code, zero pad
);

  localparam int NCH      = xyz2srgb_pkg::NUM_CH;
  localparam int IN_W     = xyz2srgb_pkg::IN_W;
  localparam int PROD_W   = xyz2srgb_pkg::PROD_W;
  localparam int SUM_W    = xyz2srgb_pkg::SUM_W;
  localparam int RND_SH   = IN_FRAC_BITS + xyz2srgb_pkg::COEF_FRAC - LINEAR_BITS;
  localparam int THR_W    = LINEAR_BITS + 1;
  localparam int TABLE_N  = 2 ** OUT_BITS;

  localparam logic signed [SUM_W-1:0] RND_HALF  = SUM_W'(64'd1 << (RND_SH - 1));
  localparam logic signed [SUM_W-1:0] LIN_MAX_S = SUM_W'((64'd1 << LINEAR_BITS) - 64'd1);
  localparam logic [LINEAR_BITS-1:0]  LIN_MAX   = '1;
  localparam logic [OUT_BITS-1:0]     CODE_MAX  = '1;

  // Stage enables: a stage loads when it is empty or its successor moves.
  logic en0, en1, en2, en3;
  logic v0, v1, v2, v3;

  // Stage payloads
  logic [IN_W-1:0]               tri_reg  [NCH];
  logic signed [PROD_W-1:0]      prod     [NCH*NCH];
  logic signed [PROD_W-1:0]      prod_next[NCH*NCH];
  logic [LINEAR_BITS-1:0]        code     [NCH];
  logic [LINEAR_BITS-1:0]        code_next[NCH];
  logic [OUT_BITS-1:0]           enc      [NCH];
  logic [OUT_BITS-1:0]           enc_next [NCH];

  // Linear-stage scratch
  logic signed [SUM_W-1:0]       lin_sum  [NCH];
  logic signed [SUM_W-1:0]       lin_rnd  [NCH];

  // Gamma search scratch
  logic [OUT_BITS-1:0]           lut_cand [NCH];
  logic [NCH-1:0]                lut_ok;

  // Encoded-value step thresholds, constant after elaboration.
  logic [THR_W-1:0]              thr      [TABLE_N];

  for (genvar gk = 0; gk < TABLE_N; gk++) begin : g_thr
    localparam int T = xyz2srgb_pkg::gamma_threshold(gk, LINEAR_BITS, OUT_BITS);
    assign thr[gk] = THR_W'(T);
  end

  assign en3 = !v3 || m_axis_tready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;

  assign s_axis_tready = en0;
  assign m_axis_tvalid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en0) v0 <= s_axis_tvalid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // Matrix products, one multiplier per coefficient.
  always_comb begin
    for (int i = 0; i < NCH * NCH; i++) begin
      prod_next[i] = $signed({1'b0, tri_reg[i % NCH]}) * xyz2srgb_pkg::XFORM[i];
    end
  end

  // Three-term sum, round half up to LINEAR_BITS fraction bits, saturate.
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      lin_sum[ch] = SUM_W'(prod[ch*NCH]) + SUM_W'(prod[ch*NCH+1]) + SUM_W'(prod[ch*NCH+2]);
      lin_rnd[ch] = (lin_sum[ch] + RND_HALF) >>> RND_SH;
      if (lin_sum[ch] <= 0) begin
        code_next[ch] = '0;
      end else if (lin_rnd[ch] > LIN_MAX_S) begin
        code_next[ch] = LIN_MAX;
      end else begin
        code_next[ch] = lin_rnd[ch][LINEAR_BITS-1:0];
      end
    end
  end

  // Binary search for the largest output code whose threshold the linear code reaches.
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      enc_next[ch] = '0;
      lut_cand[ch] = '0;
      for (int b = OUT_BITS - 1; b >= 0; b--) begin
        lut_cand[ch] = enc_next[ch] | (OUT_BITS'(1) << b);
        if ({1'b0, code[ch]} >= thr[lut_cand[ch]]) begin
          enc_next[ch] = lut_cand[ch];
        end
      end
      lut_ok[ch] = ({1'b0, code[ch]} >= thr[enc_next[ch]]) &&
                   ((enc_next[ch] == CODE_MAX) ||
                    ({1'b0, code[ch]} < thr[enc_next[ch] + OUT_BITS'(1)]));
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (en0 && s_axis_tvalid) begin
      for (int ch = 0; ch < NCH; ch++) begin
        tri_reg[ch] <= s_axis_tdata[ch*IN_W +: IN_W];
      end
    end
    if (en1 && v0) begin
      prod <= prod_next;
    end
    if (en2 && v1) begin
      code <= code_next;
    end
    if (en3 && v2) begin
      enc <= enc_next;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      m_axis_tdata[ch*OUT_BITS +: OUT_BITS] = enc[ch];
    end
  end

  // Search lands exactly on the step that holds the linear code.
  `XSE_ASSERT_HOLDS(a_lut_search, clk, rst, v2, &lut_ok)
  // Input stalls only with every stage full and the output blocked.
  `XSE_ASSERT_HOLDS(a_stall_only_full, clk, rst, !s_axis_tready, v0 && v1 && v2 && v3 && !m_axis_tready)
  // A red linear code of zero leaves the encoder as zero.
  `XSE_ASSERT_NEXT(a_black_red, clk, rst, v2 && en3 && (code[0] == '0), m_axis_tdata[OUT_BITS-1:0] == '0)

endmodule
